@@ hw/rtl/pft_pkg.sv @@
`default_nettype none

package pft_pkg;

    // Widths of the coordinate and CORDIC datapaths.
    localparam int COORD_W  = 32;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int CW       = 34;
    localparam int ANGLE_W  = 32;
    localparam int ATAN_DEPTH = 32;

    // Heading conversion: q = round(|h| * 2^26 / 360), halves away from zero.
    // 360 = 8 * 45, so q = floor((|h| * 2^23 + 22) / 45), which is split as
    // |h| * floor(2^23 / 45) + floor((|h| * (2^23 mod 45) + 22) / 45).
    localparam int DEG_HALF  = 180;
    localparam int DEG_FULL  = 2 * DEG_HALF;
    localparam int DEG_POW2  = 8;
    localparam int DEG_ODD   = DEG_FULL / DEG_POW2;
    localparam int ANG_SHIFT = 26 - 3;
    localparam longint ANG_HI  = (64'd1 << ANG_SHIFT) / DEG_ODD;
    localparam longint ANG_LO  = (64'd1 << ANG_SHIFT) % DEG_ODD;
    localparam longint ANG_RND = DEG_HALF / DEG_POW2;

    // Reciprocal of the odd factor for the residual division.
    localparam int RECIP_SHIFT = 26;
    localparam longint RECIP   = (64'd1 << RECIP_SHIFT) / DEG_ODD;

    localparam logic [CW-1:0] CORDIC_GAIN_Q30 = CW'(34'h0_26DD_3B6A);
    localparam logic [ANGLE_W-1:0] QUARTER_TURN = 32'h4000_0000;

    localparam logic signed [COORD_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] Q_MIN = 32'sh8000_0000;

    // Side information that travels with each word through the pipeline.
    typedef struct packed {
        logic                op;
        logic                flip;
        logic [DIFF_W-1:0]   a;
        logic [DIFF_W-1:0]   b;
        logic [COORD_W-1:0]  ox;
        logic [COORD_W-1:0]  oy;
    } t_side;

    // Arctangent of 2^-i in binary-angle units (2^32 is a full turn).
    function automatic logic [CW-1:0] atan_bam(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'h2000_0000;
            5'd1:  v = 32'h12E4_051D;
            5'd2:  v = 32'h09FB_385B;
            5'd3:  v = 32'h0511_11D4;
            5'd4:  v = 32'h028B_0D43;
            5'd5:  v = 32'h0145_D7E1;
            5'd6:  v = 32'h00A2_F61E;
            5'd7:  v = 32'h0051_7C55;
            5'd8:  v = 32'h0028_BE53;
            5'd9:  v = 32'h0014_5F2F;
            5'd10: v = 32'h000A_2F98;
            5'd11: v = 32'h0005_17CC;
            5'd12: v = 32'h0002_8BE6;
            5'd13: v = 32'h0001_45F3;
            5'd14: v = 32'h0000_A2F9;
            5'd15: v = 32'h0000_517C;
            5'd16: v = 32'h0000_28BE;
            5'd17: v = 32'h0000_145F;
            5'd18: v = 32'h0000_0A2F;
            5'd19: v = 32'h0000_0517;
            5'd20: v = 32'h0000_028B;
            5'd21: v = 32'h0000_0145;
            5'd22: v = 32'h0000_00A2;
            5'd23: v = 32'h0000_0051;
            5'd24: v = 32'h0000_0028;
            5'd25: v = 32'h0000_0014;
            5'd26: v = 32'h0000_000A;
            5'd27: v = 32'h0000_0005;
            5'd28: v = 32'h0000_0002;
            5'd29: v = 32'h0000_0001;
            default: v = 32'h0000_0000;
        endcase
        return {{(CW-32){1'b0}}, v};
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/planar_frame_transform_top.sv @@
`default_nettype none

// Channel | handshake                  | word fields
// --------+----------------------------+---------------------------------------------
// input   | i_in_valid / o_in_ready    | i_op, i_point_x, i_point_y, i_pose_x,
//         |                            | i_pose_y, i_pose_heading
// output  | o_out_valid / i_out_ready  | o_out_x, o_out_y, o_saturated
//
// One word is accepted per cycle and one result word leaves per cycle.
// Four stages turn the heading into a binary angle, then there is one
// register per CORDIC iteration, then sign fix-up, multiply, round and
// offset/saturate stages.
// Reset (i_rst_n low at a clock edge) clears only the valid bits.
// When a result waits and i_out_ready is low, the whole pipeline holds and
// o_in_ready drops; nothing is lost or repeated.

module planar_frame_transform_top #(
    parameter int CORDIC_STAGES = 16
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_in_valid,
    output logic                                  o_in_ready,
    input  wire                                   i_op,
    input  wire  signed [pft_pkg::COORD_W-1:0]    i_point_x,
    input  wire  signed [pft_pkg::COORD_W-1:0]    i_point_y,
    input  wire  signed [pft_pkg::COORD_W-1:0]    i_pose_x,
    input  wire  signed [pft_pkg::COORD_W-1:0]    i_pose_y,
    input  wire  signed [15:0]                    i_pose_heading,
    output logic                                  o_out_valid,
    input  wire                                   i_out_ready,
    output logic signed [pft_pkg::COORD_W-1:0]    o_out_x,
    output logic signed [pft_pkg::COORD_W-1:0]    o_out_y,
    output logic                                  o_saturated
);
    import pft_pkg::*;

    // Stages beyond the arctangent table are not run.
    localparam int NSTG = (CORDIC_STAGES > ATAN_DEPTH) ? ATAN_DEPTH : CORDIC_STAGES;
    localparam int LAST = NSTG + 7;

    // Pipeline advance: every stage moves when the output register is free
    // or is being emptied this cycle.
    logic w_adv;
    logic w_in_acc;
    logic [LAST:0] r_vld;

    assign w_adv     = !r_vld[LAST] || i_out_ready;
    assign w_in_acc  = i_in_valid && w_adv;
    assign o_in_ready = w_adv;
    assign o_out_valid = r_vld[LAST];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[LAST-1:0], w_in_acc};
        end
    end

    // ------------------------------------------------------------------
    // Stage A: heading magnitude, the two halves of the angle scaling, and
    // the point operands. For map to body the pose origin is subtracted
    // here, at full width.
    // ------------------------------------------------------------------
    logic               n_a_neg;
    logic [16:0]        n_a_mag;
    logic [19:0]        n_a_v;
    logic [31:0]        n_a_p1;
    t_side              n_a_side;
    logic [DIFF_W-1:0]  w_px, w_py, w_ox, w_oy;

    logic               r_a_neg;
    logic [19:0]        r_a_v;
    logic [31:0]        r_a_p1;
    t_side              r_a_side;

    assign w_px = {i_point_x[COORD_W-1], i_point_x};
    assign w_py = {i_point_y[COORD_W-1], i_point_y};
    assign w_ox = {i_pose_x[COORD_W-1], i_pose_x};
    assign w_oy = {i_pose_y[COORD_W-1], i_pose_y};

    always_comb begin
        n_a_neg = i_pose_heading[15];
        n_a_mag = n_a_neg ? (17'd0 - {i_pose_heading[15], i_pose_heading})
                          : {1'b0, i_pose_heading};
        n_a_v   = 20'({3'b000, n_a_mag} * 20'(ANG_LO)) + 20'(ANG_RND);
        n_a_p1  = 32'({15'd0, n_a_mag} * 32'(ANG_HI));
        n_a_side.op   = i_op;
        n_a_side.flip = 1'b0;
        n_a_side.a    = i_op ? (w_px - w_ox) : w_px;
        n_a_side.b    = i_op ? (w_py - w_oy) : w_py;
        n_a_side.ox   = i_pose_x;
        n_a_side.oy   = i_pose_y;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_neg  <= n_a_neg;
            r_a_v    <= n_a_v;
            r_a_p1   <= n_a_p1;
            r_a_side <= n_a_side;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: estimate of v / 45 by reciprocal multiplication. The
    // estimate is exact or one short.
    // ------------------------------------------------------------------
    logic [40:0] w_b_prod;
    logic [14:0] r_b_t;
    logic [19:0] r_b_v;
    logic [31:0] r_b_p1;
    logic        r_b_neg;
    t_side       r_b_side;

    assign w_b_prod = {21'd0, r_a_v} * 41'(RECIP);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_b_t    <= w_b_prod[RECIP_SHIFT +: 15];
            r_b_v    <= r_a_v;
            r_b_p1   <= r_a_p1;
            r_b_neg  <= r_a_neg;
            r_b_side <= r_a_side;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: correct the quotient and form |q| modulo 2^32.
    // ------------------------------------------------------------------
    logic [19:0] w_c_rem;
    logic [14:0] w_c_t;
    logic [31:0] r_c_q;
    logic        r_c_neg;
    t_side       r_c_side;

    assign w_c_rem = r_b_v - 20'({5'd0, r_b_t} * 20'(DEG_ODD));
    assign w_c_t   = (w_c_rem >= 20'(DEG_ODD)) ? (r_b_t + 15'd1) : r_b_t;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_c_q    <= r_b_p1 + {17'd0, w_c_t};
            r_c_neg  <= r_b_neg;
            r_c_side <= r_b_side;
        end
    end

    // ------------------------------------------------------------------
    // Stage D: signed binary angle, quadrant fold and CORDIC start values.
    // Angles in [90, 270) degrees are turned by half a circle and the
    // cosine and sine are negated at the end.
    // ------------------------------------------------------------------
    logic [31:0] w_d_b;
    logic [31:0] w_d_tmp;
    logic        w_d_flip;
    logic [31:0] w_d_z;
    t_side       n_d_side;

    logic signed [CW-1:0] r_cx [0:NSTG];
    logic signed [CW-1:0] r_cy [0:NSTG];
    logic signed [CW-1:0] r_cz [0:NSTG];
    t_side                r_cside [0:NSTG];

    assign w_d_b    = r_c_neg ? (32'd0 - r_c_q) : r_c_q;
    assign w_d_tmp  = w_d_b + QUARTER_TURN;
    assign w_d_flip = w_d_tmp[31];
    assign w_d_z    = {w_d_b[31] ^ w_d_flip, w_d_b[30:0]};

    always_comb begin
        n_d_side      = r_c_side;
        n_d_side.flip = w_d_flip;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_cx[0]    <= CORDIC_GAIN_Q30;
            r_cy[0]    <= '0;
            r_cz[0]    <= CW'($signed(w_d_z));
            r_cside[0] <= n_d_side;
        end
    end

    // ------------------------------------------------------------------
    // CORDIC rotation, one register stage per iteration.
    // ------------------------------------------------------------------
    for (genvar g = 0; g < NSTG; g++) begin : g_cordic
        localparam logic signed [CW-1:0] ATAN_G = atan_bam(5'(g));
        logic signed [CW-1:0] w_xs, w_ys;
        logic signed [CW-1:0] n_x, n_y, n_z;

        assign w_xs = r_cx[g] >>> g;
        assign w_ys = r_cy[g] >>> g;

        always_comb begin
            if (!r_cz[g][CW-1]) begin
                n_x = r_cx[g] - w_ys;
                n_y = r_cy[g] + w_xs;
                n_z = r_cz[g] - ATAN_G;
            end else begin
                n_x = r_cx[g] + w_ys;
                n_y = r_cy[g] - w_xs;
                n_z = r_cz[g] + ATAN_G;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_cx[g+1]    <= n_x;
                r_cy[g+1]    <= n_y;
                r_cz[g+1]    <= n_z;
                r_cside[g+1] <= r_cside[g];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage T: undo the quadrant fold and, for map to body, negate the
    // sine so that both directions share one rotation:
    //   rx = c*a - s*b,  ry = s*a + c*b.
    // ------------------------------------------------------------------
    logic signed [CW-1:0]     w_t_c, w_t_s;
    logic signed [DIFF_W-1:0] r_t_c, r_t_s;
    t_side                    r_t_side;

    assign w_t_c = r_cside[NSTG].flip ? -r_cx[NSTG] : r_cx[NSTG];
    assign w_t_s = (r_cside[NSTG].flip ^ r_cside[NSTG].op) ? -r_cy[NSTG] : r_cy[NSTG];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_t_c    <= DIFF_W'(w_t_c);
            r_t_s    <= DIFF_W'(w_t_s);
            r_t_side <= r_cside[NSTG];
        end
    end

    // ------------------------------------------------------------------
    // Stage M: the four products.
    // ------------------------------------------------------------------
    localparam int PW = 2 * DIFF_W;
    logic signed [PW-1:0] r_m_ca, r_m_sb, r_m_sa, r_m_cb;
    t_side                r_m_side;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m_ca   <= r_t_c * $signed(r_t_side.a);
            r_m_sb   <= r_t_s * $signed(r_t_side.b);
            r_m_sa   <= r_t_s * $signed(r_t_side.a);
            r_m_cb   <= r_t_c * $signed(r_t_side.b);
            r_m_side <= r_t_side;
        end
    end

    // ------------------------------------------------------------------
    // Stage R: exact sums, then round half up from Q30.
    // ------------------------------------------------------------------
    localparam int SW = PW + 1;
    localparam int RW = SW - 30;
    localparam logic signed [SW-1:0] HALF_Q30 = SW'(64'd1 << 29);

    logic signed [SW-1:0] w_r_sx, w_r_sy;
    logic signed [RW-1:0] r_r_x, r_r_y;
    t_side                r_r_side;

    assign w_r_sx = SW'(r_m_ca) - SW'(r_m_sb) + HALF_Q30;
    assign w_r_sy = SW'(r_m_sa) + SW'(r_m_cb) + HALF_Q30;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_r_x    <= RW'(w_r_sx >>> 30);
            r_r_y    <= RW'(w_r_sy >>> 30);
            r_r_side <= r_m_side;
        end
    end

    // ------------------------------------------------------------------
    // Stage O: add the pose origin for body to map, then saturate.
    // ------------------------------------------------------------------
    localparam int OW = RW + 1;
    logic signed [OW-1:0] w_o_x, w_o_y;
    logic signed [COORD_W-1:0] w_o_cx, w_o_cy;
    logic w_o_satx, w_o_saty;

    assign w_o_x = OW'(r_r_x) +
                   (r_r_side.op ? OW'(0) : OW'($signed(r_r_side.ox)));
    assign w_o_y = OW'(r_r_y) +
                   (r_r_side.op ? OW'(0) : OW'($signed(r_r_side.oy)));

    always_comb begin
        w_o_satx = 1'b1;
        w_o_saty = 1'b1;
        if (w_o_x > OW'(Q_MAX)) begin
            w_o_cx = Q_MAX;
        end else if (w_o_x < OW'(Q_MIN)) begin
            w_o_cx = Q_MIN;
        end else begin
            w_o_cx   = COORD_W'(w_o_x);
            w_o_satx = 1'b0;
        end
        if (w_o_y > OW'(Q_MAX)) begin
            w_o_cy = Q_MAX;
        end else if (w_o_y < OW'(Q_MIN)) begin
            w_o_cy = Q_MIN;
        end else begin
            w_o_cy   = COORD_W'(w_o_y);
            w_o_saty = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            o_out_x     <= w_o_cx;
            o_out_y     <= w_o_cy;
            o_saturated <= w_o_satx | w_o_saty;
        end
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    // An accepted word occupies the first stage in the next cycle.
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_vld[0])
        else $error("accepted word did not enter the first stage");

    // A held result freezes every valid bit in the pipeline.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> $stable(r_vld))
        else $error("pipeline moved while the output was stalled");

    // A saturated result has a coordinate sitting on a bound.
    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_saturated) |->
        (o_out_x == Q_MAX || o_out_x == Q_MIN || o_out_y == Q_MAX || o_out_y == Q_MIN))
        else $error("saturation flag without a clipped coordinate");

endmodule

`default_nettype wire
